### sv/fpa_pkg.sv
// shared types and codes for the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

    localparam logic [4:0] OP_ADD        = 5'd0;
    localparam logic [4:0] OP_SUB        = 5'd1;
    localparam logic [4:0] OP_MUL        = 5'd2;
    localparam logic [4:0] OP_DIV        = 5'd3;
    localparam logic [4:0] OP_LT         = 5'd4;
    localparam logic [4:0] OP_LE         = 5'd5;
    localparam logic [4:0] OP_GE         = 5'd6;
    localparam logic [4:0] OP_GT         = 5'd7;
    localparam logic [4:0] OP_EQ         = 5'd8;
    localparam logic [4:0] OP_NE         = 5'd9;
    localparam logic [4:0] OP_MIN        = 5'd10;
    localparam logic [4:0] OP_MAX        = 5'd11;
    localparam logic [4:0] OP_INC        = 5'd12;
    localparam logic [4:0] OP_DEC        = 5'd13;
    localparam logic [4:0] OP_FROM_INT   = 5'd14;
    localparam logic [4:0] OP_FROM_FLOAT = 5'd15;
    localparam logic [4:0] OP_TO_INT     = 5'd16;
    localparam logic [4:0] OP_TO_FLOAT   = 5'd17;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DZ    = 2'd1;
    localparam logic [1:0] ST_FLOAT = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [4:0] op;
        logic       neg;
        logic       dz;
    } ctrl_t;

endpackage

### sv/fixed_point_q24_8_alu_top.sv
// top level of the q24.8 fixed-point alu: front stage, divider cell chain, output stage
// depends on fpa_pkg, fpa_front, fpa_cell, fpa_back
//
// One transaction per cycle enters and leaves while the output is not stalled;
// every operation passes through the divider chain, which resolves one
// quotient bit per cell, and then the output register. All operations
// travel the same chain so results stay in order.
// A stall on the output holds the whole pipeline and stalls the input.
module fixed_point_q24_8_alu_top #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         opcode,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic [31:0]        float_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_raw,
    output logic [31:0]        result_float,
    output logic               compare_true,
    output logic [1:0]         status
);
    localparam int W   = WORD_WIDTH;
    localparam int DW  = WORD_WIDTH + FRAC_BITS;
    localparam int PBW = $clog2(WORD_WIDTH);
    localparam int PW  = 2 * W + PBW + 3;

    fpa_pkg::ctrl_t ctrl [0:DW];
    logic [W-1:0]   rem  [0:DW];
    logic [DW-1:0]  n    [0:DW];
    logic [DW-1:0]  q    [0:DW];
    logic [W-1:0]   d    [0:DW];
    logic [PW-1:0]  pay  [0:DW];

    logic [W-1:0]   f_res;
    logic [W-1:0]   f_fmag;
    logic [PBW-1:0] f_fpos;
    logic           f_cmp;
    logic [1:0]     f_st;
    logic           advance;

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    fpa_front #(
        .WORD_WIDTH(WORD_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .valid    (in_valid),
        .opcode   (opcode),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .float_in (float_in),
        .ctrl     (ctrl[0]),
        .dividend (n[0]),
        .divisor  (d[0]),
        .res      (f_res),
        .fmag     (f_fmag),
        .fpos     (f_fpos),
        .cmp      (f_cmp),
        .st       (f_st)
    );

    assign rem[0] = '0;
    assign q[0]   = '0;
    assign pay[0] = {f_res, f_fmag, f_fpos, f_cmp, f_st};

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        fpa_cell #(
            .WORD_WIDTH(WORD_WIDTH),
            .DW        (DW),
            .PW        (PW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctrl_in (ctrl[i]),
            .rem_in  (rem[i]),
            .n_in    (n[i]),
            .q_in    (q[i]),
            .d_in    (d[i]),
            .pay_in  (pay[i]),
            .ctrl_out(ctrl[i+1]),
            .rem_out (rem[i+1]),
            .n_out   (n[i+1]),
            .q_out   (q[i+1]),
            .d_out   (d[i+1]),
            .pay_out (pay[i+1])
        );
    end

    fpa_back #(
        .WORD_WIDTH(WORD_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .ctrl        (ctrl[DW]),
        .quo         (q[DW]),
        .res         (pay[DW][PW-1 -: W]),
        .fmag        (pay[DW][PW-W-1 -: W]),
        .fpos        (pay[DW][PBW+2 : 3]),
        .cmp         (pay[DW][2]),
        .st          (pay[DW][1:0]),
        .valid       (out_valid),
        .result_raw  (result_raw),
        .result_float(result_float),
        .compare_true(compare_true),
        .status      (status)
    );

    a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not track output backpressure");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == fpa_pkg::ST_DZ) |-> (result_raw == 32'sd0))
        else $error("divide by zero with nonzero result");

    a_float_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_float != 32'd0) |-> (result_raw == 32'sd0 && !compare_true))
        else $error("float result mixed with other fields");

    a_cmp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && compare_true) |-> (status == fpa_pkg::ST_OK))
        else $error("compare result with error status");

endmodule

### sv/fpa_front.sv
// operand decode, divider operands and all operations of the alu but divide and to-float
// depends on fpa_pkg
module fpa_front #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 8,
    parameter int DW         = WORD_WIDTH + FRAC_BITS,
    parameter int PBW        = $clog2(WORD_WIDTH)
) (
    input  logic                  valid,
    input  logic [4:0]            opcode,
    input  logic signed [31:0]    operand_a,
    input  logic signed [31:0]    operand_b,
    input  logic [31:0]           float_in,
    output fpa_pkg::ctrl_t        ctrl,
    output logic [DW-1:0]         dividend,
    output logic [WORD_WIDTH-1:0] divisor,
    output logic [WORD_WIDTH-1:0] res,
    output logic [WORD_WIDTH-1:0] fmag,
    output logic [PBW-1:0]        fpos,
    output logic                  cmp,
    output logic [1:0]            st
);
    localparam int W = WORD_WIDTH;

    logic signed [W-1:0]   a;
    logic signed [W-1:0]   b;
    logic [W-1:0]          amag;
    logic signed [2*W-1:0] prod;

    assign a    = operand_a[W-1:0];
    assign b    = operand_b[W-1:0];
    assign amag = a[W-1] ? W'(-a) : W'(a);
    assign prod = a * b;

    // sign of the quotient, or sign of the operand for to-float
    assign ctrl.valid = valid;
    assign ctrl.op    = opcode;
    assign ctrl.neg   = (opcode == fpa_pkg::OP_TO_FLOAT) ? a[W-1] : (a[W-1] ^ b[W-1]);
    assign ctrl.dz    = (b == '0);
    assign dividend   = DW'(amag) << FRAC_BITS;
    assign divisor    = b[W-1] ? W'(-b) : W'(b);
    assign fmag       = amag;

    always_comb
    begin
        fpos = '0;
        for (int i = 0; i < W; i++)
        begin
            if (amag[i])
                fpos = PBW'(i);
        end
    end

    always_comb
    begin
        logic [7:0]  ex;
        logic [23:0] mn;
        logic [63:0] fm;
        logic [63:0] lim;
        logic [W-1:0] sat;
        int s;
        int k;
        ex  = float_in[30:23];
        mn  = {ex != 8'd0, float_in[22:0]};
        s   = (ex == 8'd0 ? 1 : int'({24'd0, ex})) - 150 + FRAC_BITS;
        k   = -s;
        fm  = '0;
        if (mn != '0)
        begin
            if (s >= 0)
                fm = (s > 39) ? (64'd1 << 40) : ({40'd0, mn} << s);
            else if (k <= 25)
                fm = ({40'd0, mn} + (64'd1 << (k - 1))) >> k;
        end
        lim = float_in[31] ? (64'd1 << (W - 1)) : ((64'd1 << (W - 1)) - 64'd1);
        sat = {float_in[31], {(W-1){~float_in[31]}}};
        res = '0;
        cmp = 1'b0;
        st  = fpa_pkg::ST_OK;
        case (opcode)
            fpa_pkg::OP_ADD:      res = W'(a + b);
            fpa_pkg::OP_SUB:      res = W'(a - b);
            fpa_pkg::OP_MUL:      res = W'(prod >>> FRAC_BITS);
            fpa_pkg::OP_LT:       cmp = a < b;
            fpa_pkg::OP_LE:       cmp = a <= b;
            fpa_pkg::OP_GE:       cmp = a >= b;
            fpa_pkg::OP_GT:       cmp = a > b;
            fpa_pkg::OP_EQ:       cmp = a == b;
            fpa_pkg::OP_NE:       cmp = a != b;
            fpa_pkg::OP_MIN:      res = (a < b) ? a : b;
            fpa_pkg::OP_MAX:      res = (a > b) ? a : b;
            fpa_pkg::OP_INC:      res = W'(a + 1);
            fpa_pkg::OP_DEC:      res = W'(a - 1);
            fpa_pkg::OP_FROM_INT: res = W'(a <<< FRAC_BITS);
            fpa_pkg::OP_TO_INT:   res = W'(a >>> FRAC_BITS);
            fpa_pkg::OP_FROM_FLOAT:
            begin
                if (ex == 8'hFF)
                begin
                    st  = fpa_pkg::ST_FLOAT;
                    res = (float_in[22:0] != '0) ? '0 : sat;
                end
                else if (fm > lim)
                begin
                    st  = fpa_pkg::ST_FLOAT;
                    res = sat;
                end
                else
                begin
                    res = float_in[31] ? W'(-fm[W-1:0]) : fm[W-1:0];
                end
            end
            default: res = '0;
        endcase
    end

endmodule

### sv/fpa_cell.sv
// one quotient bit of the divider chain, carries the other results along
// depends on fpa_pkg
module fpa_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int DW         = 40,
    parameter int PW         = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  fpa_pkg::ctrl_t        ctrl_in,
    input  logic [WORD_WIDTH-1:0] rem_in,
    input  logic [DW-1:0]         n_in,
    input  logic [DW-1:0]         q_in,
    input  logic [WORD_WIDTH-1:0] d_in,
    input  logic [PW-1:0]         pay_in,
    output fpa_pkg::ctrl_t        ctrl_out,
    output logic [WORD_WIDTH-1:0] rem_out,
    output logic [DW-1:0]         n_out,
    output logic [DW-1:0]         q_out,
    output logic [WORD_WIDTH-1:0] d_out,
    output logic [PW-1:0]         pay_out
);
    localparam int W = WORD_WIDTH;

    logic           valid_reg;
    logic [4:0]     op_reg;
    logic           neg_reg;
    logic           dz_reg;
    logic [W-1:0]   rem_reg, rem_next;
    logic [DW-1:0]  n_reg, q_reg, q_next;
    logic [W-1:0]   d_reg;
    logic [PW-1:0]  pay_reg;
    logic [W:0]     remx;
    logic [W:0]     diff;

    assign remx = {rem_in, n_in[DW-1]};
    assign diff = remx - {1'b0, d_in};

    always_comb
    begin
        if (remx >= {1'b0, d_in})
        begin
            rem_next = diff[W-1:0];
            q_next   = {q_in[DW-2:0], 1'b1};
        end
        else
        begin
            rem_next = remx[W-1:0];
            q_next   = {q_in[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= ctrl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg  <= ctrl_in.op;
            neg_reg <= ctrl_in.neg;
            dz_reg  <= ctrl_in.dz;
            rem_reg <= rem_next;
            n_reg   <= {n_in[DW-2:0], 1'b0};
            q_reg   <= q_next;
            d_reg   <= d_in;
            pay_reg <= pay_in;
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign ctrl_out.op    = op_reg;
    assign ctrl_out.neg   = neg_reg;
    assign ctrl_out.dz    = dz_reg;
    assign rem_out  = rem_reg;
    assign n_out    = n_reg;
    assign q_out    = q_reg;
    assign d_out    = d_reg;
    assign pay_out  = pay_reg;

endmodule

### sv/fpa_back.sv
// result selection, divide sign fix-up, to-float rounding and output register
// depends on fpa_pkg
module fpa_back #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 8,
    parameter int DW         = WORD_WIDTH + FRAC_BITS,
    parameter int PBW        = $clog2(WORD_WIDTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  fpa_pkg::ctrl_t        ctrl,
    input  logic [DW-1:0]         quo,
    input  logic [WORD_WIDTH-1:0] res,
    input  logic [WORD_WIDTH-1:0] fmag,
    input  logic [PBW-1:0]        fpos,
    input  logic                  cmp,
    input  logic [1:0]            st,
    output logic                  valid,
    output logic signed [31:0]    result_raw,
    output logic [31:0]           result_float,
    output logic                  compare_true,
    output logic [1:0]            status
);
    localparam int W = WORD_WIDTH;

    logic              valid_reg;
    logic [W-1:0]      raw_reg, raw_next;
    logic [31:0]       flt_reg, flt_next;
    logic              cmp_reg;
    logic [1:0]        st_reg, st_next;

    always_comb
    begin
        logic [24:0] man;
        logic [W-1:0] rem;
        logic [W-1:0] half;
        int p;
        int k;
        p        = int'(fpos);
        k        = p - 23;
        man      = '0;
        rem      = '0;
        half     = '0;
        raw_next = res;
        flt_next = '0;
        st_next  = st;
        if (ctrl.op == fpa_pkg::OP_DIV)
        begin
            if (ctrl.dz)
            begin
                raw_next = '0;
                st_next  = fpa_pkg::ST_DZ;
            end
            else
            begin
                raw_next = ctrl.neg ? W'(-quo) : quo[W-1:0];
            end
        end
        else if (ctrl.op == fpa_pkg::OP_TO_FLOAT && fmag != '0)
        begin
            if (p <= 23)
            begin
                man = 25'(fmag << (23 - p));
            end
            else
            begin
                rem  = fmag & ((W'(1) << k) - W'(1));
                half = W'(1) << (k - 1);
                man  = 25'(fmag >> k);
                if (rem > half || (rem == half && man[0]))
                    man = man + 25'd1;
                if (man[24])
                begin
                    man = man >> 1;
                    p   = p + 1;
                end
            end
            flt_next = {ctrl.neg, 8'(p + 127 - FRAC_BITS), man[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw_reg <= raw_next;
            flt_reg <= flt_next;
            cmp_reg <= cmp;
            st_reg  <= st_next;
        end
    end

    assign valid        = valid_reg;
    assign result_raw   = 32'(signed'(raw_reg));
    assign result_float = flt_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

endmodule
